// ----- rtl/rmtt_pkg.sv -----
// Shared types and constants for the rotor motor thrust and torque step.
package rmtt_pkg;

    localparam logic signed [63:0] SAT64 = 64'sh7FFF_FFFF_FFFF_FFFF;

    localparam logic [4:0] ST_S2   = 5'd0;
    localparam logic [4:0] ST_TMAG = 5'd1;
    localparam logic [4:0] ST_DMAG = 5'd2;
    localparam logic [4:0] ST_LMAG = 5'd3;
    localparam logic [4:0] ST_ACL  = 5'd4;
    localparam logic [4:0] ST_RMAG = 5'd5;
    localparam logic [4:0] ST_THR  = 5'd6;
    localparam logic [4:0] ST_MOM  = 5'd9;
    localparam logic [4:0] ST_TQ   = 5'd12;
    localparam logic [4:0] ST_SQ   = 5'd24;
    localparam logic [4:0] ST_PWR  = 5'd27;

    localparam logic [2:0] REG_DECAY   = 3'd0;
    localparam logic [2:0] REG_LIMITS  = 3'd1;
    localparam logic [2:0] REG_THRUST  = 3'd2;
    localparam logic [2:0] REG_DRAG    = 3'd3;
    localparam logic [2:0] REG_INERTIA = 3'd4;
    localparam logic [2:0] REG_INVTICK = 3'd5;
    localparam logic [2:0] REG_AXIS    = 3'd6;
    localparam logic [2:0] REG_POS     = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE, S_LAG0, S_LAG1, S_LAG2, S_MUL, S_MWAIT, S_SQRT, S_SWAIT, S_DONE
    } state_t;

    typedef struct packed {
        logic               start;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic [5:0]         sh;
    } mul_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [63:0] res;
    } mul_rsp_t;

    typedef struct packed {
        logic        start;
        logic [63:0] x;
    } sqrt_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] root;
    } sqrt_rsp_t;

endpackage

// ----- rtl/rmtt_mul.sv -----
// Multi-cycle 64x64 signed multiply with shift and 64-bit saturation.
module rmtt_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  rmtt_pkg::mul_req_t req,
    output rmtt_pkg::mul_rsp_t rsp
);
    import rmtt_pkg::*;

    logic [63:0]  ma_reg, mb_reg, prod_reg;
    logic         neg_reg;
    logic [5:0]   sh_reg;
    logic [2:0]   cnt_reg;
    logic [1:0]   pos_reg;
    logic [127:0] acc_reg;
    logic         busy_reg, done_reg;
    logic signed [63:0] res_reg;

    logic [31:0]  pa, pb;
    logic [127:0] addend, shifted;
    logic [63:0]  mag;

    always_comb
    begin
        pa = cnt_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
        pb = cnt_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
        case (pos_reg)
            2'd0:    addend = {64'd0, prod_reg};
            2'd1:    addend = {32'd0, prod_reg, 32'd0};
            2'd2:    addend = {prod_reg, 64'd0};
            default: addend = 128'd0;
        endcase
        shifted = acc_reg >> sh_reg;
        mag = (shifted[127:64] != 64'd0 || shifted[63]) ? 64'(SAT64) : shifted[63:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd5)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            ma_reg  <= req.a[63] ? 64'(-req.a) : 64'(req.a);
            mb_reg  <= req.b[63] ? 64'(-req.b) : 64'(req.b);
            neg_reg <= req.a[63] ^ req.b[63];
            sh_reg  <= req.sh;
            acc_reg <= 128'd0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg <= 3'd3)
            begin
                prod_reg <= pa * pb;
                pos_reg  <= 2'({1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]});
            end
            if (cnt_reg >= 3'd1 && cnt_reg <= 3'd4)
                acc_reg <= acc_reg + addend;
            if (cnt_reg == 3'd5)
                res_reg <= neg_reg ? -$signed(mag) : $signed(mag);
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule

// ----- rtl/rmtt_sqrt.sv -----
// Bit-pair iterative integer square root of a 64-bit value.
module rmtt_sqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  rmtt_pkg::sqrt_req_t req,
    output rmtt_pkg::sqrt_rsp_t rsp
);
    import rmtt_pkg::*;

    logic [63:0] x_reg, res_reg, bit_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg   <= req.x;
            res_reg <= 64'd0;
            bit_reg <= 64'd1 << 62;
        end
        else if (busy_reg)
        begin
            if (x_reg >= trial)
            begin
                x_reg   <= x_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
                res_reg <= res_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = res_reg[31:0];

endmodule

// ----- rtl/rotor_motor_thrust_torque_step.sv -----
// Rotor motor step: speed lag, thrust, momentum, torque and power per request.
//  channel | signals                        | payload
//  s_      | s_tvalid s_tready s_tdata[31:0] | speed_command
//  m_      | m_tvalid m_tready m_tdata[351:0]| rotor_speed .. power_draw
//  cfg_    | cfg_we cfg_addr cfg_wdata       | eight registers
// Per request: a speed lag in states S_LAG0, S_LAG1 and S_LAG2, then 28 products
// on the one 32x32 multiplier (four partial products each), and 32 root steps.
// s_tready is high only in idle; a finished result waits in the output
// register, and the next request stalls at its end until m_tready frees it.
// Reset clears the kept speed and loads the register defaults.
module rotor_motor_thrust_torque_step #(
    parameter int FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // speed_command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [351:0] m_tdata,   // rotor_speed, thrust_x/y/z, torque_x/y/z,
                                    // momentum_x/y/z, power_draw
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [63:0]  cfg_wdata
);
    import rmtt_pkg::*;

    localparam logic [5:0] SH_F = 6'(FRAC_BITS);

    function automatic logic signed [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic signed [63:0] sx32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF)
            return 32'h7FFF_FFFF;
        else if (v < -64'sh8000_0000)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [63:0] sub_clamp(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] d;
        logic signed [64:0] lim;
        lim = $signed({SAT64[63], SAT64});
        d = {a[63], a} - {b[63], b};
        if (d > lim)
            return SAT64;
        else if (d < -lim)
            return -SAT64;
        return d[63:0];
    endfunction

    logic [15:0] decay_reg;
    logic [63:0] limits_reg;
    logic [31:0] thrust_c_reg, drag_c_reg, inertia_reg, invtick_reg;
    logic [48:0] axis_reg;
    logic [47:0] pos_reg;

    state_t state_reg, state_next;
    logic [4:0]  idx_reg;
    logic signed [31:0] cmd_reg, kept_reg, spd_reg;
    logic signed [49:0] lag_reg;
    logic signed [63:0] s2_reg, tmag_reg, dmag_reg, lmag_reg, acl_reg, rmag_reg, pwr_reg;
    logic signed [63:0] thr_reg [3];
    logic signed [63:0] mom_reg [3];
    logic signed [63:0] tq_reg  [3];
    logic [63:0] sum_reg;
    logic [31:0] root_reg;
    logic        out_valid_reg;
    logic [351:0] out_reg;

    mul_req_t  mreq;
    mul_rsp_t  mrsp;
    sqrt_req_t sreq;
    sqrt_rsp_t srsp;

    logic signed [63:0] ax [3];
    logic signed [63:0] th [3];
    logic signed [63:0] ps [3];
    logic signed [31:0] mn, mx;
    logic signed [49:0] q;
    logic signed [16:0] c_s;
    logic signed [17:0] w_s;
    logic [4:0] tq_off;
    logic [1:0] ti;
    logic       load;

    rmtt_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));
    rmtt_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sreq), .rsp(srsp));

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ax[i] = sx16(axis_reg[16*i +: 16]);
            th[i] = axis_reg[48] ? -ax[i] : ax[i];
            ps[i] = sx16(pos_reg[16*i +: 16]);
        end
        mn  = limits_reg[31:0];
        mx  = limits_reg[63:32];
        c_s = {1'b0, decay_reg};
        w_s = 18'sd65536 - $signed({2'b00, decay_reg});
        q   = lag_reg >>> 16;
        tq_off = idx_reg - ST_TQ;
        ti     = tq_off[3:2];
    end

    always_comb
    begin
        mreq.start = (state_reg == S_MUL);
        mreq.a  = 64'sd0;
        mreq.b  = 64'sd0;
        mreq.sh = 6'd14;
        case (idx_reg)
            ST_S2:      begin mreq.a = sx32(spd_reg); mreq.b = spd_reg[31] ?
                              -sx32(spd_reg) : sx32(spd_reg); mreq.sh = SH_F; end
            ST_TMAG:    begin mreq.a = s2_reg; mreq.b = {32'd0, thrust_c_reg};
                              mreq.sh = 6'd40; end
            ST_DMAG:    begin mreq.a = s2_reg; mreq.b = {32'd0, drag_c_reg};
                              mreq.sh = 6'd40; end
            ST_LMAG:    begin mreq.a = sx32(spd_reg); mreq.b = {32'd0, inertia_reg};
                              mreq.sh = 6'd40; end
            ST_ACL:     begin mreq.a = sx32(spd_reg) - sx32(kept_reg);
                              mreq.b = {32'd0, invtick_reg}; mreq.sh = 6'd0; end
            ST_RMAG:    begin mreq.a = acl_reg; mreq.b = {32'd0, inertia_reg};
                              mreq.sh = 6'd40; end
            ST_THR:     begin mreq.a = tmag_reg; mreq.b = th[0]; end
            ST_THR + 1: begin mreq.a = tmag_reg; mreq.b = th[1]; end
            ST_THR + 2: begin mreq.a = tmag_reg; mreq.b = th[2]; end
            ST_MOM:     begin mreq.a = lmag_reg; mreq.b = ax[0]; end
            ST_MOM + 1: begin mreq.a = lmag_reg; mreq.b = ax[1]; end
            ST_MOM + 2: begin mreq.a = lmag_reg; mreq.b = ax[2]; end
            ST_TQ:      begin mreq.a = ps[1]; mreq.b = thr_reg[2]; mreq.sh = 6'd12; end
            ST_TQ + 1:  begin mreq.a = ps[2]; mreq.b = thr_reg[1]; mreq.sh = 6'd12; end
            ST_TQ + 2:  begin mreq.a = dmag_reg; mreq.b = ax[0]; end
            ST_TQ + 3:  begin mreq.a = rmag_reg; mreq.b = ax[0]; end
            ST_TQ + 4:  begin mreq.a = ps[2]; mreq.b = thr_reg[0]; mreq.sh = 6'd12; end
            ST_TQ + 5:  begin mreq.a = ps[0]; mreq.b = thr_reg[2]; mreq.sh = 6'd12; end
            ST_TQ + 6:  begin mreq.a = dmag_reg; mreq.b = ax[1]; end
            ST_TQ + 7:  begin mreq.a = rmag_reg; mreq.b = ax[1]; end
            ST_TQ + 8:  begin mreq.a = ps[0]; mreq.b = thr_reg[1]; mreq.sh = 6'd12; end
            ST_TQ + 9:  begin mreq.a = ps[1]; mreq.b = thr_reg[0]; mreq.sh = 6'd12; end
            ST_TQ + 10: begin mreq.a = dmag_reg; mreq.b = ax[2]; end
            ST_TQ + 11: begin mreq.a = rmag_reg; mreq.b = ax[2]; end
            ST_SQ:      begin mreq.a = sx32(sat32(tq_reg[0])); mreq.b = mreq.a;
                              mreq.sh = 6'd0; end
            ST_SQ + 1:  begin mreq.a = sx32(sat32(tq_reg[1])); mreq.b = mreq.a;
                              mreq.sh = 6'd0; end
            ST_SQ + 2:  begin mreq.a = sx32(sat32(tq_reg[2])); mreq.b = mreq.a;
                              mreq.sh = 6'd0; end
            ST_PWR:     begin mreq.a = sx32(spd_reg); mreq.b = {32'd0, root_reg};
                              mreq.sh = SH_F; end
            default:    mreq.sh = 6'd0;
        endcase
        sreq.start = (state_reg == S_SQRT);
        sreq.x     = sum_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        load = 1'b0;
        case (state_reg)
            S_IDLE:  if (s_tvalid) state_next = S_LAG0;
            S_LAG0:  state_next = S_LAG1;
            S_LAG1:  state_next = S_LAG2;
            S_LAG2:  state_next = S_MUL;
            S_MUL:   state_next = S_MWAIT;
            S_MWAIT:
                if (mrsp.done)
                begin
                    if (idx_reg == ST_SQ + 5'd2)
                        state_next = S_SQRT;
                    else if (idx_reg == ST_PWR)
                        state_next = S_DONE;
                    else
                        state_next = S_MUL;
                end
            S_SQRT:  state_next = S_SWAIT;
            S_SWAIT: if (srsp.done) state_next = S_MUL;
            S_DONE:
                if (!out_valid_reg || m_tready)
                begin
                    load = 1'b1;
                    state_next = S_IDLE;
                end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= 5'd0;
            kept_reg      <= 32'sd0;
            out_valid_reg <= 1'b0;
            decay_reg     <= 16'd0;
            limits_reg    <= 64'd0;
            thrust_c_reg  <= 32'd0;
            drag_c_reg    <= 32'd0;
            inertia_reg   <= 32'd0;
            invtick_reg   <= 32'd1000;
            axis_reg      <= 49'd16384;
            pos_reg       <= 48'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_DECAY:   decay_reg    <= cfg_wdata[15:0];
                    REG_LIMITS:  limits_reg   <= cfg_wdata;
                    REG_THRUST:  thrust_c_reg <= cfg_wdata[31:0];
                    REG_DRAG:    drag_c_reg   <= cfg_wdata[31:0];
                    REG_INERTIA: inertia_reg  <= cfg_wdata[31:0];
                    REG_INVTICK: invtick_reg  <= cfg_wdata[31:0];
                    REG_AXIS:    axis_reg     <= cfg_wdata[48:0];
                    REG_POS:     pos_reg      <= cfg_wdata[47:0];
                    default:     ;
                endcase
            end
            if (state_reg == S_LAG2)
                idx_reg <= ST_S2;
            else if (state_reg == S_MWAIT && mrsp.done && idx_reg != ST_PWR)
                idx_reg <= idx_reg + 5'd1;
            if (load)
            begin
                kept_reg      <= spd_reg;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (s_tvalid)
                    cmd_reg <= s_tdata[31] ? 32'sd0 : $signed(s_tdata);
            S_LAG0:
                lag_reg <= c_s * kept_reg;
            S_LAG1:
                lag_reg <= lag_reg + w_s * cmd_reg + 50'sd32768;
            S_LAG2:
                if (q > sx32(mx))
                    spd_reg <= mx;
                else if (q < sx32(mn))
                    spd_reg <= mn;
                else
                    spd_reg <= q[31:0];
            S_MWAIT:
                if (mrsp.done)
                begin
                    if (idx_reg == ST_S2)
                        s2_reg <= mrsp.res;
                    else if (idx_reg == ST_TMAG)
                        tmag_reg <= mrsp.res;
                    else if (idx_reg == ST_DMAG)
                        dmag_reg <= mrsp.res;
                    else if (idx_reg == ST_LMAG)
                        lmag_reg <= mrsp.res;
                    else if (idx_reg == ST_ACL)
                        acl_reg <= mrsp.res;
                    else if (idx_reg == ST_RMAG)
                        rmag_reg <= mrsp.res;
                    else if (idx_reg < ST_MOM)
                        thr_reg[2'(idx_reg - ST_THR)] <= mrsp.res;
                    else if (idx_reg < ST_TQ)
                        mom_reg[2'(idx_reg - ST_MOM)] <= mrsp.res;
                    else if (idx_reg < ST_SQ)
                    begin
                        if (tq_off[1:0] == 2'd0)
                            tq_reg[ti] <= mrsp.res;
                        else
                            tq_reg[ti] <= sub_clamp(tq_reg[ti], mrsp.res);
                    end
                    else if (idx_reg == ST_SQ)
                        sum_reg <= 64'(mrsp.res);
                    else if (idx_reg < ST_PWR)
                        sum_reg <= sum_reg + 64'(mrsp.res);
                    else
                        pwr_reg <= mrsp.res;
                end
            S_SWAIT:
                if (srsp.done)
                    root_reg <= srsp.root;
            default: ;
        endcase
        if (load)
            out_reg <= {sat32(pwr_reg),
                        sat32(mom_reg[2]), sat32(mom_reg[1]), sat32(mom_reg[0]),
                        sat32(tq_reg[2]), sat32(tq_reg[1]), sat32(tq_reg[0]),
                        sat32(thr_reg[2]), sat32(thr_reg[1]), sat32(thr_reg[0]),
                        spd_reg};
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

`ifndef NO_ASSERTIONS
    a_idle_mul_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !mrsp.busy)
        else $error("multiplier busy while idle");
    a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mrsp.done |-> state_reg == S_MWAIT)
        else $error("product finished outside wait state");
    a_sqrt_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        srsp.done |-> state_reg == S_SWAIT)
        else $error("root finished outside wait state");
    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> m_tvalid)
        else $error("result load lost");
`endif

endmodule
